// ===== hdl/cgfq_pkg.sv =====
`default_nettype none

package cgfq_pkg;

    localparam int CGFQ_GUNS = 2;
    localparam int NFLAGS    = 6;
    localparam int NSELF     = 4;

    localparam int TEMP_W  = 12;
    localparam int DELAY_W = 16;
    localparam int TIME_W  = 32;

    // flag bit positions
    localparam int FLG_HOT_WARN  = 0;
    localparam int FLG_HOT_FAULT = 1;
    localparam int FLG_REV_VOLT  = 2;
    localparam int FLG_REV_CURR  = 3;
    localparam int FLG_OVER_VOLT = 4;
    localparam int FLG_OVER_CURR = 5;

    typedef enum logic [2:0] {
        REG_TEMP_WARN  = 3'd0,
        REG_TEMP_FAULT = 3'd1,
        REG_HOT_DLY    = 3'd2,
        REG_OV_DLY     = 3'd3,
        REG_OC_DLY     = 3'd4,
        REG_REV_DLY    = 3'd5,
        REG_CLR_DLY    = 3'd6
    } reg_idx_t;

    localparam logic signed [TEMP_W-1:0] RST_TEMP_WARN  = 12'sd900;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_FAULT = 12'sd1000;
    localparam logic [DELAY_W-1:0] RST_HOT_DLY = 16'd5000;
    localparam logic [DELAY_W-1:0] RST_OV_DLY  = 16'd1000;
    localparam logic [DELAY_W-1:0] RST_OC_DLY  = 16'd1000;
    localparam logic [DELAY_W-1:0] RST_REV_DLY = 16'd5000;
    localparam logic [DELAY_W-1:0] RST_CLR_DLY = 16'd5000;

    // x/10 = (x*52429)>>19 and x/100 = (x*167773)>>24, exact for 16-bit x
    localparam logic [15:0] DIV10_MUL  = 16'd52429;
    localparam int          DIV10_SH   = 19;
    localparam logic [17:0] DIV100_MUL = 18'd167773;
    localparam int          DIV100_SH  = 24;

    typedef struct packed {
        logic [NFLAGS-1:0][TIME_W-1:0] cst;
        logic [NSELF-1:0][TIME_W-1:0]  st;
        logic [NFLAGS-1:0]             flags;
    } gun_state_t;

endpackage

`default_nettype wire

// ===== hdl/cgfq_ram.sv =====
`default_nettype none

module cgfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/charger_gun_fault_qualifier_core.sv =====
`default_nettype none

// channel  direction  tdata                         tuser
// s_*      in         now_ms .. plugged (136 bits)  gun
// m_*      out        six fault flags (8 bits)      gun_out
// cfg_*    in         register write, no read-back  -
//
// One pass per cycle while m_tready is high; via stage 1, then the output register.
// Stage 0 issues the per-gun state read, stage 1 updates and writes it back;
// a same-gun pass in the next cycle takes the written word by forwarding.
// Reset clears all flags and stamps through per-gun valid bits, no sweep.
// A stalled m side holds one result plus one pass in stage 1.

module charger_gun_fault_qualifier_core
    import cgfq_pkg::*;
#(
    parameter int GUNS = CGFQ_GUNS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // now_ms[31:0] temp_a[43:32] temp_b[55:44] out_volt[66:56] meter_volt[81:67]
    // meter_curr[97:82] req_volt[113:98] req_curr[129:114] charging[130] plugged[131]
    input  wire logic [135:0] s_tdata,
    // gun[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hot_warn[0] hot_fault[1] reverse_volt[2] reverse_curr[3] over_volt[4] over_curr[5]
    output logic [7:0]        m_tdata,
    // gun_out[0]
    output logic              m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam int GAW = (GUNS > 1) ? $clog2(GUNS) : 1;
    localparam int SW  = $bits(gun_state_t);

    // configuration
    logic signed [TEMP_W-1:0] warn_lvl_reg, fault_lvl_reg;
    logic [DELAY_W-1:0] hot_dly_reg, ov_dly_reg, oc_dly_reg, rev_dly_reg, clr_dly_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_lvl_reg  <= RST_TEMP_WARN;
            fault_lvl_reg <= RST_TEMP_FAULT;
            hot_dly_reg   <= RST_HOT_DLY;
            ov_dly_reg    <= RST_OV_DLY;
            oc_dly_reg    <= RST_OC_DLY;
            rev_dly_reg   <= RST_REV_DLY;
            clr_dly_reg   <= RST_CLR_DLY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP_WARN:  warn_lvl_reg  <= cfg_data[TEMP_W-1:0];
                REG_TEMP_FAULT: fault_lvl_reg <= cfg_data[TEMP_W-1:0];
                REG_HOT_DLY:    hot_dly_reg   <= cfg_data;
                REG_OV_DLY:     ov_dly_reg    <= cfg_data;
                REG_OC_DLY:     oc_dly_reg    <= cfg_data;
                REG_REV_DLY:    rev_dly_reg   <= cfg_data;
                REG_CLR_DLY:    clr_dly_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: accept, quotients, state read
    logic s_xfer, s1_adv, wr_en;
    logic [GAW-1:0] in_addr, wr_addr;
    logic [31:0] v10_prod;
    logic [33:0] v100_prod;
    logic [31:0] a10_prod;
    logic [33:0] a100_prod;

    assign s_xfer  = s_tvalid && s_tready;
    assign in_addr = GAW'(s_tuser);

    assign v10_prod  = {16'd0, s_tdata[113:98]} * {16'd0, DIV10_MUL};
    assign v100_prod = {18'd0, s_tdata[113:98]} * {16'd0, DIV100_MUL};
    assign a10_prod  = {16'd0, s_tdata[129:114]} * {16'd0, DIV10_MUL};
    assign a100_prod = {18'd0, s_tdata[129:114]} * {16'd0, DIV100_MUL};

    logic        s1_valid_reg;
    logic        s1_gun_reg, s1_inrange_reg, s1_fwd_reg, s1_init_reg;
    logic [31:0] s1_now_reg;
    logic signed [11:0] s1_ta_reg, s1_tb_reg;
    logic [10:0] s1_ov_reg;
    logic        s1_mvneg_reg;
    logic signed [15:0] s1_mc_reg;
    logic [12:0] s1_v10_reg, s1_a10_reg;
    logic [9:0]  s1_v100_reg, s1_a100_reg;
    logic        s1_chg_reg, s1_plg_reg;
    logic [GUNS-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            s1_gun_reg     <= s_tuser;
            s1_inrange_reg <= (int'(s_tuser) < GUNS);
            s1_fwd_reg     <= wr_en && (wr_addr == in_addr);
            s1_init_reg    <= vld_reg[in_addr];
            s1_now_reg     <= s_tdata[31:0];
            s1_ta_reg      <= s_tdata[43:32];
            s1_tb_reg      <= s_tdata[55:44];
            s1_ov_reg      <= s_tdata[66:56];
            s1_mvneg_reg   <= s_tdata[81];
            s1_mc_reg      <= s_tdata[97:82];
            s1_v10_reg     <= v10_prod[DIV10_SH +: 13];
            s1_v100_reg    <= v100_prod[DIV100_SH +: 10];
            s1_a10_reg     <= a10_prod[DIV10_SH +: 13];
            s1_a100_reg    <= a100_prod[DIV100_SH +: 10];
            s1_chg_reg     <= s_tdata[130];
            s1_plg_reg     <= s_tdata[131];
        end
    end

    gun_state_t ram_q, wb_reg, cur, word_next;
    logic [SW-1:0] ram_rdata;

    cgfq_ram #(
        .WIDTH (SW),
        .DEPTH (GUNS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (word_next),
        .re    (s_xfer),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    assign ram_q = gun_state_t'(ram_rdata);

    // stage 1: update and write back
    assign wr_en   = s1_valid_reg && s1_adv && s1_inrange_reg;
    assign wr_addr = GAW'(s1_gun_reg);

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            cur = wb_reg;
        end
        else if (s1_init_reg)
        begin
            cur = ram_q;
        end
        else
        begin
            cur = '0;
        end
    end

    logic [NFLAGS-1:0] cond, age_ok;
    logic [NSELF-1:0]  clr_ok;
    logic [DELAY_W-1:0] dly [NFLAGS];
    logic [16:0] a10_x10, a100_x10;
    logic [13:0] ov_lim;
    logic signed [17:0] mc_x, oc_lim;

    always_comb
    begin
        a10_x10  = {1'b0, s1_a10_reg, 3'b000} + {3'b000, s1_a10_reg, 1'b0};
        a100_x10 = {4'b0000, s1_a100_reg, 3'b000} + {6'b000000, s1_a100_reg, 1'b0};
        ov_lim   = {1'b0, s1_v10_reg} + {4'b0000, s1_v100_reg};
        mc_x     = 18'(s1_mc_reg);
        oc_lim   = {1'b0, a10_x10} + {1'b0, a100_x10};

        cond[FLG_HOT_WARN]  = (s1_ta_reg >= warn_lvl_reg) || (s1_tb_reg >= warn_lvl_reg);
        cond[FLG_HOT_FAULT] = (s1_ta_reg >= fault_lvl_reg) || (s1_tb_reg >= fault_lvl_reg);
        cond[FLG_REV_VOLT]  = s1_mvneg_reg;
        cond[FLG_REV_CURR]  = s1_mc_reg[15];
        cond[FLG_OVER_VOLT] = s1_chg_reg && ({3'b000, s1_ov_reg} > {1'b0, s1_v10_reg})
                              && ({3'b000, s1_ov_reg} >= ov_lim);
        cond[FLG_OVER_CURR] = s1_chg_reg && (mc_x > $signed({1'b0, a10_x10}))
                              && (mc_x >= oc_lim);

        dly[FLG_HOT_WARN]  = hot_dly_reg;
        dly[FLG_HOT_FAULT] = hot_dly_reg;
        dly[FLG_REV_VOLT]  = rev_dly_reg;
        dly[FLG_REV_CURR]  = rev_dly_reg;
        dly[FLG_OVER_VOLT] = ov_dly_reg;
        dly[FLG_OVER_CURR] = oc_dly_reg;

        for (int k = 0; k < NFLAGS; k++)
        begin
            age_ok[k] = (s1_now_reg - cur.cst[k]) >= {16'd0, dly[k]};
        end
        for (int k = 0; k < NSELF; k++)
        begin
            clr_ok[k] = (s1_now_reg - cur.st[k]) >= {16'd0, clr_dly_reg};
        end
    end

    always_comb
    begin
        word_next = cur;
        for (int k = 0; k < NSELF; k++)
        begin
            if (cond[k])
            begin
                if (age_ok[k] && !cur.flags[k])
                begin
                    word_next.flags[k] = 1'b1;
                    word_next.st[k]    = s1_now_reg;
                end
            end
            else
            begin
                word_next.cst[k] = s1_now_reg;
                if (cur.flags[k] && clr_ok[k])
                begin
                    word_next.flags[k] = 1'b0;
                end
            end
        end
        for (int k = NSELF; k < NFLAGS; k++)
        begin
            if (cond[k])
            begin
                if (age_ok[k])
                begin
                    word_next.flags[k] = 1'b1;
                end
            end
            else
            begin
                word_next.cst[k] = s1_now_reg;
            end
            if (!s1_plg_reg)
            begin
                word_next.flags[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wb_reg <= word_next;
        end
    end

    // output register
    logic       m_valid_reg;
    logic [5:0] m_flags_reg;
    logic       m_gun_reg;

    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv)
        begin
            m_gun_reg   <= s1_gun_reg;
            m_flags_reg <= s1_inrange_reg ? word_next.flags : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_flags_reg};
    assign m_tuser  = m_gun_reg;

endmodule

`default_nettype wire
